>>> rtl/outlier_rejecting_median_unit_macros.svh
// Assertion helpers for the RTL file that checks its own logic.
`ifndef OUTLIER_REJECTING_MEDIAN_UNIT_MACROS_SVH
`define OUTLIER_REJECTING_MEDIAN_UNIT_MACROS_SVH

// Same-cycle implication.
`define ORMU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ormu: same-cycle check failed");

// Next-cycle implication.
`define ORMU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ormu: next-cycle check failed");

`endif

>>> rtl/ormu_pkg.sv
`default_nettype none
package ormu_pkg;
   localparam int SAMPLE_W = 24;
   localparam int MEDIAN_W = 25;
   localparam int KEPT_W   = 7;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // Controls that every sorter cell sees in the same cycle.
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;
endpackage
`default_nettype wire

>>> rtl/ormu_cell.sv
`default_nettype none
module ormu_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  ormu_pkg::cell_ctl_type ctl,
   input  wire                    in_valid,
   input  ormu_pkg::sample_type   in_data,
   input  wire                    right_valid,
   input  ormu_pkg::sample_type   right_data,
   output logic                   out_valid,
   output ormu_pkg::sample_type   out_data,
   output logic                   held_valid,
   output ormu_pkg::sample_type   held_data
);
   import ormu_pkg::*;

   logic       held_valid_ff;
   sample_type held_data_ff;
   logic       tok_valid_ff;
   sample_type tok_data_ff;

   // The cell keeps the smaller of its value and the arriving one and hands
   // the larger to its right neighbor in the next cycle; a shift takes the right neighbor's value.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         held_valid_ff <= 1'b0;
         tok_valid_ff  <= 1'b0;
      end else if (ctl.shift) begin
         held_valid_ff <= right_valid;
         held_data_ff  <= right_data;
         tok_valid_ff  <= 1'b0;
      end else begin
         tok_valid_ff <= in_valid && held_valid_ff;
         if (in_valid) begin
            if (!held_valid_ff) begin
               held_valid_ff <= 1'b1;
               held_data_ff  <= in_data;
            end else if (in_data < held_data_ff) begin
               held_data_ff <= in_data;
               tok_data_ff  <= held_data_ff;
            end else begin
               tok_data_ff  <= in_data;
            end
         end
      end
   end

   assign out_valid  = tok_valid_ff;
   assign out_data   = tok_data_ff;
   assign held_valid = held_valid_ff;
   assign held_data  = held_data_ff;
endmodule
`default_nettype wire

>>> rtl/ormu_mul.sv
`default_nettype none
module ormu_mul #(
   parameter int A_W = 80,
   parameter int B_W = 34
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             start,
   input  wire [A_W-1:0]   a,
   input  wire [B_W-1:0]   b,
   output logic            done,
   output logic [A_W-1:0]  product
);
   logic           busy_ff;
   logic [A_W-1:0] a_ff;
   logic [B_W-1:0] b_ff;
   logic [A_W-1:0] acc_ff;

   // Shift-and-add: one multiplier bit per cycle, finishes when no bits remain.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         a_ff    <= a;
         b_ff    <= b;
         acc_ff  <= '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_ff <= acc_ff + a_ff;
            end
            a_ff <= a_ff << 1;
            b_ff <= b_ff >> 1;
         end
      end
   end

   assign done    = busy_ff && (b_ff == '0);
   assign product = acc_ff;
endmodule
`default_nettype wire

>>> rtl/outlier_rejecting_median_unit.sv
// Outlier-rejecting median. Timing samples stream in on req, one transfer
// per cycle while req_tready is high, and are stored until a transfer with
// req_tlast set closes the set. With MIN_FILTER_COUNT or more samples, each
// sample is tested exactly against two sample standard deviations of the
// mean; if enough survive, the median is taken over the survivors,
// otherwise over all samples. The result is twice the median with its count
// and two flags. Samples beyond MAX_SAMPLES are dropped and flagged. The
// time to close a set is dominated by the bit-serial shift-and-add
// multiplier used for the squared deviations, whose run shortens with the
// bit length of each deviation. The sort itself runs in a chain of
// compare-and-pass cells as samples are fed. req_tready is low while a set
// is being closed. A finished result waits in the output register; a
// following set can load meanwhile.
`default_nettype none
module outlier_rejecting_median_unit #(
   parameter int MAX_SAMPLES      = 64,
   parameter int MIN_FILTER_COUNT = 5
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [23:0] sample
   input  wire         req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [24:0] median_doubled, [31:25] kept_count
   output logic [1:0]  rsp_tuser    // [0] outliers_removed, [1] overflowed
);
   import ormu_pkg::*;
   `include "outlier_rejecting_median_unit_macros.svh"

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SW = SAMPLE_W + CW;          // sum and n*v
   localparam int PW = 2 * SW + CW + 2;        // products and bound

   typedef enum logic [3:0] {
      S_LOAD, S_SUM, S_SPREAD, S_SPREAD_MUL, S_TEST, S_TEST_MUL1,
      S_TEST_MUL2, S_CHECK, S_FEED_ALL, S_DRAIN, S_POP, S_FINISH
   } state_type;

   state_type  state_ff;
   logic [CW-1:0] count_ff;
   logic          ovf_ff;
   logic [CW-1:0] idx_ff;
   logic          rd_ok_ff;
   logic [SW-1:0] sum_ff;
   logic [PW-1:0] spread_ff;
   logic [CW-1:0] surv_ff;
   logic [CW-1:0] kept_ff;
   logic          filtered_ff;
   logic [CW-1:0] pos_ff;
   sample_type    v_ff;
   sample_type    lo_ff;
   logic          ins_valid_ff;
   sample_type    ins_data_ff;
   logic          mul_start_ff;
   logic [PW-1:0] mul_a_ff;
   logic [SW-1:0] mul_b_ff;
   logic          rsp_tvalid_ff;
   logic [MEDIAN_W-1:0] median_ff;
   logic [MEDIAN_W-1:0] median_out_ff;
   logic [KEPT_W-1:0]   kept_out_ff;
   logic          filt_out_ff;
   logic          ovf_out_ff;

   sample_type    mem [MAX_SAMPLES];
   sample_type    rd_q_ff;

   logic          req_acc;
   logic          room;
   logic [CW-1:0] count_in;
   logic          last_idx;
   logic [SW-1:0] nv;
   logic [SW-1:0] dev;
   logic [PW-1:0] bound;
   logic          mul_done;
   logic [PW-1:0] mul_prod;
   logic [CW-1:0] half;
   logic          load_rsp;
   logic [31:0]   kept_wide;
   cell_ctl_type  cell_ctl;

   logic       tok_valid [MAX_SAMPLES+1];
   sample_type tok_data  [MAX_SAMPLES+1];
   logic       held_valid [MAX_SAMPLES+1];
   sample_type held_data  [MAX_SAMPLES+1];

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign room       = (count_ff < CW'(MAX_SAMPLES));
   assign count_in   = room ? count_ff + 1'b1 : count_ff;
   assign last_idx   = (idx_ff == count_ff - 1'b1);
   assign nv         = SW'(count_ff) * SW'(rd_q_ff);
   assign dev        = (nv >= sum_ff) ? nv - sum_ff : sum_ff - nv;
   assign bound      = spread_ff << 2;
   assign half       = kept_ff >> 1;
   assign load_rsp   = (state_ff == S_FINISH) && (!rsp_tvalid_ff || rsp_tready);
   assign kept_wide  = 32'(kept_ff);

   // Sample store: one write per accepted sample while there is room, registered read.
   always_ff @(posedge clock) begin
      if (req_acc && room) begin
         mem[count_ff[AW-1:0]] <= req_tdata;
      end
      rd_q_ff <= mem[idx_ff[AW-1:0]];
   end

   ormu_mul #(.A_W(PW), .B_W(SW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (mul_b_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Sorter chain: inserts enter at cell 0, the smallest ends up there.
   always_comb begin
      cell_ctl.clear = (state_ff == S_FINISH) ||
                       ((state_ff == S_CHECK) && (32'(surv_ff) < MIN_FILTER_COUNT));
      cell_ctl.shift = (state_ff == S_POP);
   end

   assign tok_valid[0]           = ins_valid_ff;
   assign tok_data[0]            = ins_data_ff;
   assign held_valid[MAX_SAMPLES] = 1'b0;
   assign held_data[MAX_SAMPLES]  = '0;

   for (genvar gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
      ormu_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .in_valid    (tok_valid[gi]),
         .in_data     (tok_data[gi]),
         .right_valid (held_valid[gi+1]),
         .right_data  (held_data[gi+1]),
         .out_valid   (tok_valid[gi+1]),
         .out_data    (tok_data[gi+1]),
         .held_valid  (held_valid[gi]),
         .held_data   (held_data[gi])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         ins_valid_ff  <= 1'b0;
         mul_start_ff  <= 1'b0;
         rd_ok_ff      <= 1'b0;
      end else begin
         // An insert goes out for each survivor of the test and for each sample fed
         // when all are kept; a multiply starts on each fresh read and after the first test product.
         ins_valid_ff <= ((state_ff == S_TEST_MUL2) && mul_done && (mul_prod <= bound)) ||
                         ((state_ff == S_FEED_ALL) && rd_ok_ff);
         mul_start_ff <= (((state_ff == S_SPREAD) || (state_ff == S_TEST)) && rd_ok_ff) ||
                         ((state_ff == S_TEST_MUL1) && mul_done);
         if (load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  count_ff <= count_in;
                  if (!room) begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     idx_ff      <= '0;
                     rd_ok_ff    <= 1'b0;
                     sum_ff      <= '0;
                     spread_ff   <= '0;
                     surv_ff     <= '0;
                     filtered_ff <= 1'b0;
                     state_ff    <= (32'(count_in) >= MIN_FILTER_COUNT) ? S_SUM : S_FEED_ALL;
                  end
               end
            end
            S_SUM: begin
               rd_ok_ff <= !rd_ok_ff;
               if (rd_ok_ff) begin
                  sum_ff <= sum_ff + SW'(rd_q_ff);
                  if (last_idx) begin
                     idx_ff   <= '0;
                     state_ff <= S_SPREAD;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_SPREAD: begin
               rd_ok_ff <= !rd_ok_ff;
               if (rd_ok_ff) begin
                  mul_a_ff     <= PW'(dev);
                  mul_b_ff     <= dev;
                  state_ff     <= S_SPREAD_MUL;
               end
            end
            S_SPREAD_MUL: begin
               if (mul_done) begin
                  spread_ff <= spread_ff + mul_prod;
                  if (last_idx) begin
                     idx_ff   <= '0;
                     state_ff <= S_TEST;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_SPREAD;
                  end
               end
            end
            S_TEST: begin
               rd_ok_ff <= !rd_ok_ff;
               if (rd_ok_ff) begin
                  v_ff         <= rd_q_ff;
                  mul_a_ff     <= PW'(dev);
                  mul_b_ff     <= dev;
                  state_ff     <= S_TEST_MUL1;
               end
            end
            S_TEST_MUL1: begin
               if (mul_done) begin
                  mul_a_ff     <= mul_prod;
                  mul_b_ff     <= SW'(count_ff - 1'b1);
                  state_ff     <= S_TEST_MUL2;
               end
            end
            S_TEST_MUL2: begin
               if (mul_done) begin
                  if (mul_prod <= bound) begin
                     ins_data_ff  <= v_ff;
                     surv_ff      <= surv_ff + 1'b1;
                  end
                  if (last_idx) begin
                     idx_ff   <= '0;
                     state_ff <= S_CHECK;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_TEST;
                  end
               end
            end
            S_CHECK: begin
               pos_ff <= '0;
               if (32'(surv_ff) >= MIN_FILTER_COUNT) begin
                  filtered_ff <= 1'b1;
                  kept_ff     <= surv_ff;
                  state_ff    <= S_DRAIN;
               end else begin
                  state_ff <= S_FEED_ALL;
               end
            end
            S_FEED_ALL: begin
               rd_ok_ff <= !rd_ok_ff;
               if (rd_ok_ff) begin
                  ins_data_ff  <= rd_q_ff;
                  if (last_idx) begin
                     kept_ff  <= count_ff;
                     pos_ff   <= '0;
                     state_ff <= S_DRAIN;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_DRAIN: begin
               // Let the last insert settle through the whole chain.
               if (pos_ff == CW'(MAX_SAMPLES)) begin
                  pos_ff   <= '0;
                  state_ff <= S_POP;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            S_POP: begin
               pos_ff <= pos_ff + 1'b1;
               if ((half != '0) && (pos_ff == half - 1'b1)) begin
                  lo_ff <= held_data[0];
               end
               if (pos_ff == half) begin
                  if (kept_ff[0]) begin
                     median_ff <= {held_data[0], 1'b0};
                  end else begin
                     median_ff <= {1'b0, lo_ff} + {1'b0, held_data[0]};
                  end
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // The result register takes the new result only once the
               // previous one has been transferred.
               if (load_rsp) begin
                  median_out_ff <= median_ff;
                  kept_out_ff   <= kept_wide[KEPT_W-1:0];
                  filt_out_ff   <= filtered_ff;
                  ovf_out_ff    <= ovf_ff;
                  count_ff      <= '0;
                  ovf_ff        <= 1'b0;
                  state_ff      <= S_LOAD;
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {kept_out_ff, median_out_ff};
   assign rsp_tuser  = {ovf_out_ff, filt_out_ff};

   // The store count never runs past capacity.
   `ORMU_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_SAMPLES))
   // No sample ever falls off the far end of the sorter chain.
   `ORMU_ASSERT_IMPL(a_chain_room, clock, reset, 1'b1, !tok_valid[MAX_SAMPLES])
   // A filtered result always covers at least the minimum count.
   `ORMU_ASSERT_IMPL(a_filter_min, clock, reset, load_rsp && filtered_ff,
                     32'(kept_ff) >= MIN_FILTER_COUNT)
   // Loading a result returns to sample loading with the result pending.
   `ORMU_ASSERT_NEXT(a_rsp_load, clock, reset, load_rsp, rsp_tvalid && req_tready)
endmodule
`default_nettype wire

>>> sim/ormu_median_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ormu_median_checker #(
   parameter int MAX_SAMPLES      = 64,
   parameter int MIN_FILTER_COUNT = 5
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [23:0] req_tdata,
   input  wire         req_tlast,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [31:0] rsp_tdata,
   input  wire  [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count
);
   import ormu_pkg::*;

   typedef struct packed {
      logic [MEDIAN_W-1:0] median_doubled;
      logic [KEPT_W-1:0]   kept_count;
      logic                outliers_removed;
      logic                overflowed;
   } median_result_t;

   sample_type     held_samples[MAX_SAMPLES];
   int             held_count;
   logic           dropped_any;
   median_result_t median_queue[$];

   assign pending_count = median_queue.size();

   // Works out the result of the set held so far, closed by a last sample.
   function automatic median_result_t median_of_set();
      median_result_t res;
      logic [127:0]   total, spread, bound, dev, lhs;
      logic [127:0]   dev_of[MAX_SAMPLES];
      bit             keep[MAX_SAMPLES];
      int unsigned    chosen[$];
      int             n, survivors, m;
      n = held_count;
      total = 0;
      spread = 0;
      res = '0;
      for (int i = 0; i < n; i++) keep[i] = 1;
      if (n >= MIN_FILTER_COUNT) begin
         for (int i = 0; i < n; i++) total += held_samples[i];
         for (int i = 0; i < n; i++) begin
            dev = n * held_samples[i];
            dev = (dev >= total) ? dev - total : total - dev;
            dev_of[i] = dev;
            spread += dev * dev;
         end
         bound = spread << 2;
         survivors = 0;
         for (int i = 0; i < n; i++) begin
            lhs = dev_of[i] * dev_of[i] * (n - 1);
            keep[i] = (lhs <= bound);
            survivors += keep[i];
         end
         if (survivors >= MIN_FILTER_COUNT) res.outliers_removed = 1'b1;
         else for (int i = 0; i < n; i++) keep[i] = 1;
      end
      for (int i = 0; i < n; i++)
         if (keep[i]) chosen.insert(chosen.size(), held_samples[i]);
      chosen.sort();
      m = chosen.size();
      if (m > 0) begin
         if (m % 2 == 0) res.median_doubled = MEDIAN_W'(chosen[m/2-1] + chosen[m/2]);
         else res.median_doubled = MEDIAN_W'(2 * chosen[m/2]);
      end
      res.kept_count = KEPT_W'(m);
      res.overflowed = dropped_any;
      return res;
   endfunction

   always @(posedge clock) begin
      median_result_t want, got;
      if (reset) begin
         held_count  = 0;
         dropped_any = 1'b0;
         fail_count  = 0;
      end else begin
         // Input side: store the sample; a last sample closes the set.
         if (req_tvalid && req_tready) begin
            if (held_count < MAX_SAMPLES) begin
               held_samples[held_count] = req_tdata;
               held_count = held_count + 1;
            end else begin
               dropped_any = 1'b1;
            end
            if (req_tlast) begin
               median_queue.insert(median_queue.size(), median_of_set());
               held_count  = 0;
               dropped_any = 1'b0;
            end
         end
         // Result side: compare against the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            got.median_doubled   = rsp_tdata[24:0];
            got.kept_count       = rsp_tdata[31:25];
            got.outliers_removed = rsp_tuser[0];
            got.overflowed       = rsp_tuser[1];
            if (median_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result transfer: median %0d kept %0d",
                           got.median_doubled, got.kept_count);
               fail_count = fail_count + 1;
            end else begin
               want = median_queue.pop_front();
               if (want !== got) begin
                  if (fail_count < 10)
                     $display("mismatch: expected median %0d kept %0d rm %0b ovf %0b,",
                              want.median_doubled, want.kept_count,
                              want.outliers_removed, want.overflowed,
                              " got median %0d kept %0d rm %0b ovf %0b",
                              got.median_doubled, got.kept_count,
                              got.outliers_removed, got.overflowed);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> sim/outlier_rejecting_median_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// Stimulus and verdict for the outlier-rejecting median unit. The checker
// beside the block predicts every result and counts failures.
module outlier_rejecting_median_unit_tb;
   localparam int TARGET_ITEMS = 1900;
   localparam int CYCLE_LIMIT  = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [23:0] sample
   logic        req_tlast = 1'b0; // last_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [24:0] median_doubled, [31:25] kept_count
   logic [1:0]  rsp_tuser;        // [0] outliers_removed, [1] overflowed

   int fail_count, pending_count;
   int tx_idle_pct = 17;
   int rx_idle_pct = 53;
   int items_sent  = 0;
   bit want_hold   = 0;
   int cycle_count = 0;

   outlier_rejecting_median_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   ormu_median_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver. A hold request turns into a long stretch with tready low,
   // counted here, so that the block fills up and stalls its input.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (want_hold) begin
            want_hold = 0;
            hold_left = 4000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offers one sample and waits for its transfer. Valid stays high between
   // back-to-back transfers; it only drops for an idle cycle.
   task automatic send_sample(input logic [23:0] value, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Sends a set of n samples. Kinds: 0 uniform over the full range,
   // 1 a tight cluster with occasional far outliers, 2 all equal.
   task automatic send_set(input int n, input int kind);
      logic [23:0] base, value;
      base = 24'($urandom_range(24'hFFF000, 24'h001000));
      for (int i = 0; i < n; i++) begin
         case (kind)
            0: value = 24'($urandom);
            1: value = ($urandom_range(99) < 12) ? 24'($urandom)
                                                 : 24'(base + $urandom_range(2000) - 1000);
            default: value = base;
         endcase
         send_sample(value, i == n - 1);
      end
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int n, roll, phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, a two-sample median, too few to filter,
      // exactly enough to filter with one outlier, a set with all samples
      // equal, a six-sample cluster.
      send_sample(24'h000000, 1'b1);
      send_sample(24'hFFFFFF, 1'b1);
      send_sample(24'h000000, 1'b0);
      send_sample(24'hFFFFFF, 1'b1);
      send_set(4, 1);
      send_sample(24'd100, 1'b0);
      send_sample(24'd101, 1'b0);
      send_sample(24'd99, 1'b0);
      send_sample(24'd100, 1'b0);
      send_sample(24'hFFFFFF, 1'b1);
      send_set(5, 2);
      send_set(6, 1);

      // Random part in three idling phases.
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         if (items_sent * 3 / TARGET_ITEMS > phase) begin
            phase++;
            // Sender pauses until every expected result has come back.
            drain_results();
            if (phase == 1) begin
               tx_idle_pct = 53;
               rx_idle_pct = 17;
               want_hold = 1;
            end else begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         end
         roll = $urandom_range(99);
         if (roll < 85) n = $urandom_range(12, 1);
         else if (roll < 95) n = $urandom_range(40, 13);
         else n = $urandom_range(70, 60);   // near, at and past capacity
         send_set(n, $urandom_range(99) < 60 ? 1 : ($urandom_range(9) < 8 ? 0 : 2));
      end
      drain_results();
      repeat (6000) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
